FILE: hdl/kvmn_pkg.sv
`timescale 1ns / 1ps

package kvmn_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int MAX_VERTS_DEF  = 1024;

  localparam int POS_W      = 24;
  localparam int NRM_W      = 16;
  localparam int PHASE_W    = 17;
  localparam int FRAME_W    = 6;
  localparam int END_W      = 7;
  localparam int VIDX_W     = 10;
  localparam int DIFF_W     = 25;
  localparam int CROSS_W    = 51;
  localparam int MUL_W      = 31;
  localparam int PROD_W     = 62;
  localparam int MAG_W      = 30;
  localparam int ROOT_W     = 31;
  localparam int QUO_W      = 15;
  localparam int NUM_W      = 45;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [FRAME_W-1:0] START_RST = 6'd0;
  localparam logic [END_W-1:0]   END_RST   = 7'd1;
  localparam logic [PHASE_W-1:0] STEP_RST  = 17'd6554;
  localparam logic [FRAME_W-1:0] NEXT_RST  = 6'd1;
  localparam logic [PHASE_W-1:0] PHASE_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    CFG_START_FRAME = 2'd0,
    CFG_END_FRAME   = 2'd1,
    CFG_PHASE_STEP  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_TRI   = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_BEGIN,
    CMD_END,
    CMD_READ,
    CMD_BLEND,
    CMD_DIFF,
    CMD_CROSS,
    CMD_ABS,
    CMD_SHIFT,
    CMD_SQUARE,
    CMD_ROOT,
    CMD_DIV,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    cmd_t       code;
    logic [1:0] crn;
    logic [2:0] sub;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic deg;
    logic big;
    logic root_busy;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [FRAME_W-1:0]      frame_index;
    logic [VIDX_W-1:0]       vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [VIDX_W-1:0]       corner_a;
    logic [VIDX_W-1:0]       corner_b;
    logic [VIDX_W-1:0]       corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    degenerate;
    logic                    last_corner;
  } out_item_t;

endpackage

FILE: hdl/keyframe_vertex_morph_normal.sv
// The input stalls while any item is processed; a new item is taken only in idle.
// A triangle's time grows with each normalising shift of the cross product and
// with any output stall; a degenerate one skips the square root and divisions.
// Most of it goes to the 31-step square root and three 15-step divisions, with
// one store read port giving 6 reads per triangle.
// Synchronous active-low reset clears control state; the vertex store is not cleared.
`timescale 1ns / 1ps

module keyframe_vertex_morph_normal #(
  parameter int MAX_FRAMES = kvmn_pkg::MAX_FRAMES_DEF,
  parameter int MAX_VERTS  = kvmn_pkg::MAX_VERTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kvmn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kvmn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kvmn_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output kvmn_pkg::out_item_t               out_data
);

  kvmn_pkg::dp_cmd_t  cmd;
  kvmn_pkg::dp_stat_t stat;
  logic               in_take;

  assign in_take = in_valid && !in_stall;

  kvmn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kvmn_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_VERTS  (MAX_VERTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (in_take),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/kvmn_root.sv
`timescale 1ns / 1ps

module kvmn_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [kvmn_pkg::PROD_W-1:0]   radicand,
  output logic                          busy,
  output logic [kvmn_pkg::ROOT_W-1:0]   root
);

  logic                        busy_r;
  logic [4:0]                  cnt_r;
  logic [kvmn_pkg::PROD_W-1:0] rad_r;
  logic [32:0]                 rem_r;
  logic [kvmn_pkg::ROOT_W-1:0] root_r;

  logic [34:0] rem_sh;
  logic [34:0] trial;

  assign rem_sh = {rem_r, rad_r[kvmn_pkg::PROD_W-1 -: 2]};
  assign trial  = 35'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(kvmn_pkg::ROOT_W - 1);
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= 33'(rem_sh - trial);
        root_r <= {root_r[kvmn_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[32:0];
        root_r <= {root_r[kvmn_pkg::ROOT_W-2:0], 1'b0};
      end
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

FILE: hdl/kvmn_div.sv
`timescale 1ns / 1ps

module kvmn_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kvmn_pkg::NUM_W-1:0]   num,
  input  logic [kvmn_pkg::ROOT_W-1:0]  den,
  output logic                         busy,
  output logic                         done,
  output logic [kvmn_pkg::QUO_W-1:0]   quo
);

  localparam int QW = kvmn_pkg::QUO_W;
  localparam int RW = kvmn_pkg::ROOT_W;

  logic          busy_r, done_r;
  logic [3:0]    cnt_r;
  logic [RW-1:0] rem_r, den_r;
  logic [QW-1:0] low_r, quo_r;
  logic [RW:0]   sh;

  // quotient never exceeds 2^15, so the top bits seed the remainder directly
  assign sh = {rem_r, low_r[QW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'(QW - 1);
        rem_r  <= RW'(num[kvmn_pkg::NUM_W-1:QW]);
        low_r  <= num[QW-1:0];
        den_r  <= den;
        quo_r  <= '0;
      end else if (busy_r) begin
        low_r <= low_r << 1;
        if (sh >= {1'b0, den_r}) begin
          rem_r <= RW'(sh - {1'b0, den_r});
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= sh[RW-1:0];
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hdl/kvmn_dp.sv
`timescale 1ns / 1ps

module kvmn_dp #(
  parameter int MAX_FRAMES = kvmn_pkg::MAX_FRAMES_DEF,
  parameter int MAX_VERTS  = kvmn_pkg::MAX_VERTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kvmn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kvmn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_take,
  input  kvmn_pkg::in_item_t                in_data,
  input  kvmn_pkg::dp_cmd_t                 cmd,
  output kvmn_pkg::dp_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output kvmn_pkg::out_item_t               out_data
);

  localparam int DEPTH = MAX_FRAMES * MAX_VERTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = kvmn_pkg::POS_W;
  localparam int FW    = kvmn_pkg::FRAME_W;
  localparam int XW    = kvmn_pkg::CROSS_W;
  localparam int MW    = kvmn_pkg::MUL_W;
  localparam int RW    = kvmn_pkg::PROD_W;

  kvmn_pkg::in_item_t  in_r;
  kvmn_pkg::out_item_t out_r;
  logic                out_valid_r;

  logic [FW-1:0]                    start_r;
  logic [kvmn_pkg::END_W-1:0]       end_r;
  logic [kvmn_pkg::PHASE_W-1:0]     step_r;
  logic [FW-1:0]                    frame_cur_r, frame_nxt_r;
  logic [kvmn_pkg::PHASE_W-1:0]     phase_r;

  logic [3*PW-1:0] mem [DEPTH];
  logic [3*PW-1:0] mem_q_r;
  logic            rd_tag_r, rd_nxt_r, rd_zero_r;

  logic signed [PW-1:0]             vc_r [3];
  logic signed [PW-1:0]             vn_r [3];
  logic signed [PW-1:0]             pos_r [3][3];
  logic signed [kvmn_pkg::DIFF_W-1:0] u_r [3];
  logic signed [kvmn_pkg::DIFF_W-1:0] w_r [3];
  logic signed [XW-1:0]             cr_r [3];
  logic [XW-1:0]                    mag_r [3];
  logic [RW-1:0]                    sum_r;
  logic signed [kvmn_pkg::NRM_W-1:0] nrm_r [3];
  logic                             deg_r;
  logic [1:0]                       div_k_r;
  logic signed [RW-1:0]             prod_r;

  kvmn_pkg::cmd_t acc_code_r;
  logic [1:0]     acc_crn_r;
  logic [2:0]     acc_sub_r;

  logic                  ld_ok, rd_ok, out_free, big;
  logic [AW-1:0]         ld_addr, rd_addr;
  logic [FW-1:0]         rd_frame;
  logic [kvmn_pkg::VIDX_W-1:0] rd_vx;
  logic signed [kvmn_pkg::DIFF_W-1:0] bl_d;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [RW-1:0]  bl_t, bl_s, bl_p;
  logic signed [PW-1:0]  bl_sat;
  logic [kvmn_pkg::END_W-1:0] seq_c, seq_n;
  logic [kvmn_pkg::PHASE_W:0] ph_sum;
  logic [1:0]            emit_p;
  logic                  root_busy, div_busy, div_done;
  logic [kvmn_pkg::ROOT_W-1:0] root_q;
  logic [kvmn_pkg::QUO_W-1:0]  div_q;
  logic [kvmn_pkg::NUM_W-1:0]  div_num;
  logic [kvmn_pkg::NRM_W-1:0]  q16;

  function automatic logic signed [kvmn_pkg::DIFF_W-1:0] DIFF_W_CAST(
    input logic signed [kvmn_pkg::POS_W-1:0] v);
    return kvmn_pkg::DIFF_W'(v);
  endfunction

  assign ld_ok = (32'(in_r.frame_index) < 32'(MAX_FRAMES)) &&
                 (32'(in_r.vertex_index) < 32'(MAX_VERTS));
  assign ld_addr = ld_ok ? AW'(32'(in_r.frame_index) * 32'(MAX_VERTS) +
                              32'(in_r.vertex_index)) : '0;

  always_comb begin
    rd_frame = cmd.sub[0] ? frame_nxt_r : frame_cur_r;
    case (cmd.crn)
      2'd1:    rd_vx = in_r.corner_b;
      2'd2:    rd_vx = in_r.corner_c;
      default: rd_vx = in_r.corner_a;
    endcase
  end

  assign rd_ok   = (32'(rd_frame) < 32'(MAX_FRAMES)) && (32'(rd_vx) < 32'(MAX_VERTS));
  assign rd_addr = rd_ok ? AW'(32'(rd_frame) * 32'(MAX_VERTS) + 32'(rd_vx)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.code == kvmn_pkg::CMD_LOAD && ld_ok) begin
      mem[ld_addr] <= {in_r.pos_x, in_r.pos_y, in_r.pos_z};
    end
    if (cmd.code == kvmn_pkg::CMD_READ) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // shared multiplier operands
  assign bl_d = DIFF_W_CAST(vn_r[cmd.sub[1:0]]) - DIFF_W_CAST(vc_r[cmd.sub[1:0]]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.code)
      kvmn_pkg::CMD_BLEND: begin
        mul_a = MW'(bl_d);
        mul_b = MW'(signed'({1'b0, phase_r}));
      end
      kvmn_pkg::CMD_CROSS: begin
        case (cmd.sub)
          3'd0:    begin mul_a = MW'(u_r[1]); mul_b = MW'(w_r[2]); end
          3'd1:    begin mul_a = MW'(w_r[1]); mul_b = MW'(u_r[2]); end
          3'd2:    begin mul_a = MW'(w_r[0]); mul_b = MW'(u_r[2]); end
          3'd3:    begin mul_a = MW'(u_r[0]); mul_b = MW'(w_r[2]); end
          3'd4:    begin mul_a = MW'(u_r[0]); mul_b = MW'(w_r[1]); end
          default: begin mul_a = MW'(w_r[0]); mul_b = MW'(u_r[1]); end
        endcase
      end
      kvmn_pkg::CMD_SQUARE: begin
        mul_a = signed'({1'b0, mag_r[cmd.sub[1:0]][kvmn_pkg::MAG_W-1:0]});
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // blend rounding: floor((d + 32768) / 65536), add the current vertex, then saturate
  always_comb begin
    bl_t = prod_r + 62'sd32768;
    bl_s = bl_t >>> 16;
    bl_p = bl_s + RW'(vc_r[acc_sub_r[1:0]]);
    if (bl_p > 62'sd8388607)       bl_sat = 24'sh7FFFFF;
    else if (bl_p < -62'sd8388608) bl_sat = 24'sh800000;
    else                           bl_sat = bl_p[PW-1:0];
  end

  always_comb begin
    seq_c = {1'b0, frame_cur_r} + 7'd1;
    if (seq_c >= end_r) seq_c = {1'b0, start_r};
    seq_n = {1'b0, seq_c[FW-1:0]} + 7'd1;
    if (seq_n >= end_r) seq_n = {1'b0, start_r};
    ph_sum = {1'b0, phase_r} + {1'b0, step_r};
  end

  assign big = (|mag_r[0][XW-1:kvmn_pkg::MAG_W]) || (|mag_r[1][XW-1:kvmn_pkg::MAG_W]) ||
               (|mag_r[2][XW-1:kvmn_pkg::MAG_W]);

  assign div_num = kvmn_pkg::NUM_W'({mag_r[cmd.sub[1:0]][kvmn_pkg::MAG_W-1:0], 14'b0}) +
                   kvmn_pkg::NUM_W'(root_q[kvmn_pkg::ROOT_W-1:1]);
  assign q16 = {1'b0, div_q};

  kvmn_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.code == kvmn_pkg::CMD_ROOT),
    .radicand (sum_r),
    .busy     (root_busy),
    .root     (root_q)
  );

  kvmn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.code == kvmn_pkg::CMD_DIV),
    .num   (div_num),
    .den   (root_q),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (cmd.crn)
      2'd0:    emit_p = 2'd0;
      2'd1:    emit_p = 2'd2;
      default: emit_p = 2'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= kvmn_pkg::START_RST;
      end_r       <= kvmn_pkg::END_RST;
      step_r      <= kvmn_pkg::STEP_RST;
      frame_cur_r <= '0;
      frame_nxt_r <= kvmn_pkg::NEXT_RST;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      rd_tag_r    <= 1'b0;
      acc_code_r  <= kvmn_pkg::CMD_NOP;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kvmn_pkg::CFG_START_FRAME: start_r <= cfg_data[FW-1:0];
          kvmn_pkg::CFG_END_FRAME:   end_r   <= cfg_data[kvmn_pkg::END_W-1:0];
          kvmn_pkg::CFG_PHASE_STEP:  step_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.code == kvmn_pkg::CMD_BEGIN) begin
        priority if (phase_r == '0) begin
          frame_cur_r <= start_r;
        end else if (phase_r[kvmn_pkg::PHASE_W-1]) begin
          phase_r     <= '0;
          frame_cur_r <= seq_c[FW-1:0];
          frame_nxt_r <= seq_n[FW-1:0];
        end else begin
        end
      end
      if (cmd.code == kvmn_pkg::CMD_END) begin
        phase_r <= ph_sum[kvmn_pkg::PHASE_W] ? kvmn_pkg::PHASE_MAX
                                             : ph_sum[kvmn_pkg::PHASE_W-1:0];
      end
      rd_tag_r <= (cmd.code == kvmn_pkg::CMD_READ);
      if (cmd.code == kvmn_pkg::CMD_BLEND || cmd.code == kvmn_pkg::CMD_CROSS ||
          cmd.code == kvmn_pkg::CMD_SQUARE) begin
        acc_code_r <= cmd.code;
      end else begin
        acc_code_r <= kvmn_pkg::CMD_NOP;
      end
      if (cmd.code == kvmn_pkg::CMD_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_r <= in_data;
    acc_crn_r <= cmd.crn;
    acc_sub_r <= cmd.sub;
    if (cmd.code == kvmn_pkg::CMD_READ) begin
      rd_nxt_r  <= cmd.sub[0];
      rd_zero_r <= !rd_ok;
    end
    if (rd_tag_r) begin
      for (int k = 0; k < 3; k++) begin
        if (rd_nxt_r) vn_r[k] <= rd_zero_r ? '0 : mem_q_r[(2-k)*PW +: PW];
        else          vc_r[k] <= rd_zero_r ? '0 : mem_q_r[(2-k)*PW +: PW];
      end
    end
    unique case (acc_code_r)
      kvmn_pkg::CMD_BLEND:  pos_r[acc_crn_r][acc_sub_r[1:0]] <= bl_sat;
      kvmn_pkg::CMD_CROSS: begin
        if (!acc_sub_r[0]) cr_r[acc_sub_r[2:1]] <= XW'(prod_r);
        else cr_r[acc_sub_r[2:1]] <= cr_r[acc_sub_r[2:1]] - XW'(prod_r);
      end
      kvmn_pkg::CMD_SQUARE: begin
        sum_r <= ((acc_sub_r[1:0] == 2'd0) ? '0 : sum_r) + $unsigned(prod_r);
      end
      default: ;
    endcase
    if (cmd.code == kvmn_pkg::CMD_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        u_r[k] <= DIFF_W_CAST(pos_r[0][k]) - DIFF_W_CAST(pos_r[2][k]);
        w_r[k] <= DIFF_W_CAST(pos_r[0][k]) - DIFF_W_CAST(pos_r[1][k]);
      end
    end
    if (cmd.code == kvmn_pkg::CMD_ABS) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= cr_r[k][XW-1] ? XW'(-cr_r[k]) : XW'(cr_r[k]);
        nrm_r[k] <= '0;
      end
      deg_r <= (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
    end
    if (cmd.code == kvmn_pkg::CMD_SHIFT) begin
      for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
    end
    if (cmd.code == kvmn_pkg::CMD_DIV) div_k_r <= cmd.sub[1:0];
    if (div_done) nrm_r[div_k_r] <= cr_r[div_k_r][XW-1] ? -q16 : q16;
    if (cmd.code == kvmn_pkg::CMD_EMIT && out_free) begin
      out_r.out_x       <= pos_r[emit_p][0];
      out_r.out_y       <= pos_r[emit_p][1];
      out_r.out_z       <= pos_r[emit_p][2];
      out_r.normal_x    <= nrm_r[0];
      out_r.normal_y    <= nrm_r[1];
      out_r.normal_z    <= nrm_r[2];
      out_r.degenerate  <= deg_r;
      out_r.last_corner <= cmd.last;
    end
  end

  assign stat.deg       = deg_r;
  assign stat.big       = big;
  assign stat.root_busy = root_busy;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.code == kvmn_pkg::CMD_EMIT && out_free) |=> out_valid_r)
    else $error("emit did not load the output register");

  a_square_normalised: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.code == kvmn_pkg::CMD_SQUARE) |-> !big)
    else $error("square taken before magnitudes were normalised");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.code == kvmn_pkg::CMD_EMIT && deg_r) |->
      (nrm_r[0] == '0 && nrm_r[1] == '0 && nrm_r[2] == '0))
    else $error("degenerate triangle with non-zero normal");

endmodule

FILE: hdl/kvmn_ctrl.sv
`timescale 1ns / 1ps

module kvmn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_stall,
  input  kvmn_pkg::dp_stat_t  stat,
  output kvmn_pkg::dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_ONE, S_RD_CUR, S_RD_NXT, S_RD_WAIT, S_BLEND, S_BL_WAIT, S_DIFF,
    S_CROSS, S_CR_WAIT, S_ABS, S_CHECK, S_SHIFT, S_SQ, S_SQ_WAIT, S_ROOT,
    S_ROOT_WAIT, S_DIV, S_DIV_WAIT, S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  kvmn_pkg::dp_cmd_t cmd_r, cmd_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cmd_nxt.code  = kvmn_pkg::CMD_NOP;
    cmd_nxt.last  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            kvmn_pkg::OP_LOAD:  begin state_nxt = S_ONE; cmd_nxt.code = kvmn_pkg::CMD_LOAD;  end
            kvmn_pkg::OP_BEGIN: begin state_nxt = S_ONE; cmd_nxt.code = kvmn_pkg::CMD_BEGIN; end
            kvmn_pkg::OP_END:   begin state_nxt = S_ONE; cmd_nxt.code = kvmn_pkg::CMD_END;   end
            kvmn_pkg::OP_TRI: begin
              state_nxt    = S_RD_CUR;
              cmd_nxt.code = kvmn_pkg::CMD_READ;
              cmd_nxt.crn  = 2'd0;
              cmd_nxt.sub  = 3'd0;
            end
          endcase
        end
      end
      S_ONE: state_nxt = S_IDLE;
      S_RD_CUR: begin
        state_nxt    = S_RD_NXT;
        cmd_nxt.code = kvmn_pkg::CMD_READ;
        cmd_nxt.sub  = 3'd1;
      end
      S_RD_NXT:  state_nxt = S_RD_WAIT;
      S_RD_WAIT: begin
        state_nxt    = S_BLEND;
        cmd_nxt.code = kvmn_pkg::CMD_BLEND;
        cmd_nxt.sub  = 3'd0;
      end
      S_BLEND: begin
        priority if (cmd_r.sub < 3'd2) begin
          cmd_nxt.code = kvmn_pkg::CMD_BLEND;
          cmd_nxt.sub  = cmd_r.sub + 3'd1;
        end else if (cmd_r.crn < 2'd2) begin
          state_nxt    = S_RD_CUR;
          cmd_nxt.code = kvmn_pkg::CMD_READ;
          cmd_nxt.crn  = cmd_r.crn + 2'd1;
          cmd_nxt.sub  = 3'd0;
        end else begin
          state_nxt = S_BL_WAIT;
        end
      end
      S_BL_WAIT: begin
        state_nxt    = S_DIFF;
        cmd_nxt.code = kvmn_pkg::CMD_DIFF;
      end
      S_DIFF: begin
        state_nxt    = S_CROSS;
        cmd_nxt.code = kvmn_pkg::CMD_CROSS;
        cmd_nxt.sub  = 3'd0;
      end
      S_CROSS: begin
        if (cmd_r.sub < 3'd5) begin
          cmd_nxt.code = kvmn_pkg::CMD_CROSS;
          cmd_nxt.sub  = cmd_r.sub + 3'd1;
        end else begin
          state_nxt = S_CR_WAIT;
        end
      end
      S_CR_WAIT: begin
        state_nxt    = S_ABS;
        cmd_nxt.code = kvmn_pkg::CMD_ABS;
      end
      S_ABS: state_nxt = S_CHECK;
      S_CHECK: begin
        priority if (stat.deg) begin
          state_nxt    = S_EMIT;
          cmd_nxt.code = kvmn_pkg::CMD_EMIT;
          cmd_nxt.crn  = 2'd0;
        end else if (stat.big) begin
          state_nxt    = S_SHIFT;
          cmd_nxt.code = kvmn_pkg::CMD_SHIFT;
        end else begin
          state_nxt    = S_SQ;
          cmd_nxt.code = kvmn_pkg::CMD_SQUARE;
          cmd_nxt.sub  = 3'd0;
        end
      end
      S_SHIFT: state_nxt = S_CHECK;
      S_SQ: begin
        if (cmd_r.sub < 3'd2) begin
          cmd_nxt.code = kvmn_pkg::CMD_SQUARE;
          cmd_nxt.sub  = cmd_r.sub + 3'd1;
        end else begin
          state_nxt = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        state_nxt    = S_ROOT;
        cmd_nxt.code = kvmn_pkg::CMD_ROOT;
      end
      S_ROOT: state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: begin
        if (!stat.root_busy) begin
          state_nxt    = S_DIV;
          cmd_nxt.code = kvmn_pkg::CMD_DIV;
          cmd_nxt.sub  = 3'd0;
        end
      end
      S_DIV: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        priority if (stat.div_busy) begin
        end else if (cmd_r.sub < 3'd2) begin
          state_nxt    = S_DIV;
          cmd_nxt.code = kvmn_pkg::CMD_DIV;
          cmd_nxt.sub  = cmd_r.sub + 3'd1;
        end else begin
          state_nxt    = S_EMIT;
          cmd_nxt.code = kvmn_pkg::CMD_EMIT;
          cmd_nxt.crn  = 2'd0;
        end
      end
      S_EMIT: begin
        priority if (!stat.out_free) begin
          cmd_nxt = cmd_r;
        end else if (cmd_r.crn < 2'd2) begin
          cmd_nxt.code = kvmn_pkg::CMD_EMIT;
          cmd_nxt.crn  = cmd_r.crn + 2'd1;
          cmd_nxt.last = (cmd_r.crn == 2'd1);
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= '{code: kvmn_pkg::CMD_NOP, crn: 2'd0, sub: 3'd0, last: 1'b0};
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd      = cmd_r;

endmodule

FILE: sim/keyframe_vertex_morph_normal_checker.sv
`timescale 1ns / 1ps

module keyframe_vertex_morph_normal_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [kvmn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kvmn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  kvmn_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  kvmn_pkg::out_item_t             out_data,
  output int                              errors,
  output int                              pending
);

  int pos_mem [3][65536];
  int start_f, end_f, step_q;
  int cur_f, nxt_f, phase_q;
  kvmn_pkg::out_item_t corner_q[$];
  int corners_seen;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at corner %0d: %s got %0d expected %0d", corners_seen, what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] slot(input int f, input int v);
    return 16'(f * 1024 + v);
  endfunction

  function automatic longint blend_axis(input int k, input int vx);
    longint c, n, d, p;
    c = longint'(pos_mem[k][slot(cur_f, vx)]);
    n = longint'(pos_mem[k][slot(nxt_f, vx)]);
    d = (n - c) * longint'(phase_q);
    p = c + ((d + 32768) >>> 16);
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic morph_triangle(input kvmn_pkg::in_item_t it);
    longint pa[3], pb[3], pc[3], u[3], w[3], cr[3], nrm[3];
    longint unsigned mag[3], mx, sum, len, q;
    kvmn_pkg::out_item_t e;
    logic deg;
    for (int k = 0; k < 3; k++) begin
      pa[k] = blend_axis(k, int'(it.corner_a));
      pb[k] = blend_axis(k, int'(it.corner_b));
      pc[k] = blend_axis(k, int'(it.corner_c));
      u[k] = pa[k] - pc[k];
      w[k] = pa[k] - pb[k];
      nrm[k] = 0;
    end
    cr[0] = u[1] * w[2] - w[1] * u[2];
    cr[1] = w[0] * u[2] - u[0] * w[2];
    cr[2] = u[0] * w[1] - w[0] * u[1];
    deg = (cr[0] == 0) && (cr[1] == 0) && (cr[2] == 0);
    if (!deg) begin
      mx = 0;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = cr[k] < 0 ? longint'(-cr[k]) : longint'(cr[k]);
        if (mag[k] > mx) mx = mag[k];
      end
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
      end
      for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
      len = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
        q = (mag[k] * 16384 + len / 2) / len;
        nrm[k] = cr[k] < 0 ? -longint'(q) : longint'(q);
      end
    end
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin e.out_x = pa[0][23:0]; e.out_y = pa[1][23:0]; e.out_z = pa[2][23:0]; end
        1: begin e.out_x = pc[0][23:0]; e.out_y = pc[1][23:0]; e.out_z = pc[2][23:0]; end
        default: begin e.out_x = pb[0][23:0]; e.out_y = pb[1][23:0]; e.out_z = pb[2][23:0]; end
      endcase
      e.normal_x = nrm[0][15:0];
      e.normal_y = nrm[1][15:0];
      e.normal_z = nrm[2][15:0];
      e.degenerate = deg;
      e.last_corner = (r == 2);
      corner_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_f = int'(kvmn_pkg::START_RST);
      end_f = int'(kvmn_pkg::END_RST);
      step_q = int'(kvmn_pkg::STEP_RST);
      cur_f = 0;
      nxt_f = int'(kvmn_pkg::NEXT_RST);
      phase_q = 0;
      errors = 0;
      corners_seen = 0;
      corner_q.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (kvmn_pkg::cfg_reg_t'(cfg_index))
          kvmn_pkg::CFG_START_FRAME: start_f = int'(cfg_data[5:0]);
          kvmn_pkg::CFG_END_FRAME:   end_f = int'(cfg_data[6:0]);
          kvmn_pkg::CFG_PHASE_STEP:  step_q = int'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (kvmn_pkg::op_t'(in_data.op))
          kvmn_pkg::OP_LOAD: begin
            pos_mem[0][slot(int'(in_data.frame_index), int'(in_data.vertex_index))] =
              int'(in_data.pos_x);
            pos_mem[1][slot(int'(in_data.frame_index), int'(in_data.vertex_index))] =
              int'(in_data.pos_y);
            pos_mem[2][slot(int'(in_data.frame_index), int'(in_data.vertex_index))] =
              int'(in_data.pos_z);
          end
          kvmn_pkg::OP_BEGIN: begin
            int c, n;
            if (phase_q == 0) cur_f = start_f;
            if (phase_q >= 65536) begin
              phase_q = 0;
              c = cur_f + 1;
              if (c >= end_f) c = start_f;
              c = c & 63;
              n = c + 1;
              if (n >= end_f) n = start_f;
              cur_f = c;
              nxt_f = n & 63;
            end
          end
          kvmn_pkg::OP_END: begin
            phase_q = phase_q + step_q;
            if (phase_q > 131071) phase_q = 131071;
          end
          default: morph_triangle(in_data);
        endcase
      end
      if (out_valid && !out_stall) begin
        if (corner_q.size() == 0) begin
          $display("unexpected corner transfer %0d", corners_seen);
          errors++;
        end else begin
          kvmn_pkg::out_item_t e;
          e = corner_q.pop_front();
          if (out_data.out_x !== e.out_x)
            report_mismatch("x", longint'(out_data.out_x), longint'(e.out_x));
          if (out_data.out_y !== e.out_y)
            report_mismatch("y", longint'(out_data.out_y), longint'(e.out_y));
          if (out_data.out_z !== e.out_z)
            report_mismatch("z", longint'(out_data.out_z), longint'(e.out_z));
          if (out_data.normal_x !== e.normal_x)
            report_mismatch("normal_x", longint'(out_data.normal_x), longint'(e.normal_x));
          if (out_data.normal_y !== e.normal_y)
            report_mismatch("normal_y", longint'(out_data.normal_y), longint'(e.normal_y));
          if (out_data.normal_z !== e.normal_z)
            report_mismatch("normal_z", longint'(out_data.normal_z), longint'(e.normal_z));
          if (out_data.degenerate !== e.degenerate)
            report_mismatch("degenerate", longint'(out_data.degenerate),
                            longint'(e.degenerate));
          if (out_data.last_corner !== e.last_corner)
            report_mismatch("last_corner", longint'(out_data.last_corner),
                            longint'(e.last_corner));
        end
        corners_seen++;
      end
      pending = corner_q.size();
    end
  end

endmodule

FILE: sim/keyframe_vertex_morph_normal_test.sv
`timescale 1ns / 1ps

module keyframe_vertex_morph_normal_test;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [kvmn_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kvmn_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  kvmn_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  kvmn_pkg::out_item_t             out_data;
  int                              errors;
  int                              pending;

  logic calm;
  int   stall_left;
  int   tri_count, load_count, other_count, setting_count;
  logic [kvmn_pkg::VIDX_W-1:0] vsel [8] =
    '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd1022, 10'd1023};

  keyframe_vertex_morph_normal u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  keyframe_vertex_morph_normal_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= int'($urandom_range(0, 2));
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input kvmn_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    case (kvmn_pkg::op_t'(it.op))
      kvmn_pkg::OP_LOAD: load_count++;
      kvmn_pkg::OP_TRI:  tri_count++;
      default: other_count++;
    endcase
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic kvmn_pkg::in_item_t rand_item(input kvmn_pkg::op_t op);
    kvmn_pkg::in_item_t it;
    it.op = op;
    it.frame_index = 6'($urandom_range(0, 63));
    it.vertex_index = vsel[3'($urandom_range(0, 7))];
    it.pos_x = 24'($urandom);
    it.pos_y = 24'($urandom);
    it.pos_z = 24'($urandom);
    case ($urandom_range(0, 7))
      0: it.pos_x = 24'h7FFFFF;
      1: it.pos_y = 24'h800000;
      2: it.pos_z = 24'h7FFFFF;
      default: ;
    endcase
    it.corner_a = vsel[3'($urandom_range(0, 7))];
    it.corner_b = vsel[3'($urandom_range(0, 7))];
    it.corner_c = vsel[3'($urandom_range(0, 7))];
    return it;
  endfunction

  function automatic kvmn_pkg::in_item_t tri_item(input int a, input int b, input int c);
    kvmn_pkg::in_item_t it;
    it = rand_item(kvmn_pkg::OP_TRI);
    it.corner_a = 10'(a);
    it.corner_b = 10'(b);
    it.corner_c = 10'(c);
    return it;
  endfunction

  function automatic kvmn_pkg::in_item_t load_item(input int f, input int v,
                                                   input int x, input int y, input int z);
    kvmn_pkg::in_item_t it;
    it = rand_item(kvmn_pkg::OP_LOAD);
    it.frame_index = 6'(f);
    it.vertex_index = 10'(v);
    it.pos_x = 24'(x);
    it.pos_y = 24'(y);
    it.pos_z = 24'(z);
    return it;
  endfunction

  task automatic set_registers(input int s, input int e, input int step);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= kvmn_pkg::CFG_START_FRAME;
    cfg_data <= 17'(s);
    @(posedge clk);
    cfg_index <= kvmn_pkg::CFG_END_FRAME;
    cfg_data <= 17'(e);
    @(posedge clk);
    cfg_index <= kvmn_pkg::CFG_PHASE_STEP;
    cfg_data <= 17'(step);
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin
    int s_tab[5] = '{0, 63, 10, 0, 5};
    int e_tab[5] = '{16, 1, 14, 2, 16};
    int p_tab[5] = '{65536, 1, 30000, 6554, 40000};
    int n;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    calm = 1'b0;
    tri_count = 0;
    load_count = 0;
    other_count = 0;
    setting_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // frames 0 to 15 and 63 are the only ones the sequencer reaches
    for (int f = 0; f < 17; f++)
      for (int v = 0; v < 8; v++)
        send_item(load_item((f == 16) ? 63 : f, int'(vsel[v]), int'($urandom),
                            int'($urandom), int'($urandom)));

    // directed: extremes, degenerate triangles and phase steps at the reset settings
    send_item(load_item(0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_item(load_item(0, 1, 24'h800000, 24'h800000, 24'h800000));
    send_item(load_item(0, 2, 24'h7FFFFF, 24'h800000, 0));
    send_item(load_item(1, 0, 24'h800000, 24'h7FFFFF, 24'h800000));
    send_item(load_item(1, 1, 24'h7FFFFF, 0, 24'h7FFFFF));
    send_item(load_item(1, 2, 0, 0, 0));
    send_item(rand_item(kvmn_pkg::OP_BEGIN));
    send_item(tri_item(0, 1, 2));
    send_item(tri_item(3, 3, 3));
    send_item(tri_item(1023, 0, 1022));
    send_item(rand_item(kvmn_pkg::OP_END));
    send_item(tri_item(0, 1, 2));
    send_item(rand_item(kvmn_pkg::OP_END));
    send_item(rand_item(kvmn_pkg::OP_END));
    send_item(tri_item(0, 2, 1));
    send_item(rand_item(kvmn_pkg::OP_BEGIN));
    send_item(tri_item(0, 1, 2));
    send_item(tri_item(4, 4, 5));
    send_item(rand_item(kvmn_pkg::OP_END));
    send_item(rand_item(kvmn_pkg::OP_BEGIN));
    send_item(tri_item(1023, 1022, 0));

    for (int ph = 0; ph < 5; ph++) begin
      set_registers(s_tab[ph], e_tab[ph], p_tab[ph]);
      if (ph == 4) calm = 1'b1;
      n = 0;
      while (n < 32) begin
        if ($urandom_range(0, 9) < 2) begin
          send_item(rand_item(kvmn_pkg::op_t'($urandom_range(0, 3))));
          n++;
        end else begin
          send_item(rand_item(kvmn_pkg::OP_BEGIN));
          n++;
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 5) == 0) send_item(rand_item(kvmn_pkg::OP_LOAD));
            send_item(rand_item(kvmn_pkg::OP_TRI));
            n++;
          end
          repeat ($urandom_range(1, 2)) begin
            send_item(rand_item(kvmn_pkg::OP_END));
            n++;
          end
        end
      end
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("%0d triangles, %0d loads, %0d sequencer items over %0d register settings",
             tri_count, load_count, other_count, setting_count);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d corners outstanding", pending);
    $display("simulation failed");
    $finish;
  end

endmodule
